// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the renderer top level and its output queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DBA_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define DBA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Invariant that holds on every clock edge out of reset.
`define DBA_ASSERT_ALWAYS(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/dba_pkg.sv
// Types, constants and helper functions of the depth bin ASCII renderer.
`timescale 1ns / 1ps

package dba_pkg;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_COLUMN_STEP  = 2'd2;
    localparam logic [1:0] REG_ROW_GROUP    = 2'd3;

    // Register reset values
    localparam logic [10:0] WIDTH_RST  = 11'd320;
    localparam logic [10:0] HEIGHT_RST = 11'd240;
    localparam logic [4:0]  STEP_RST   = 5'd3;
    localparam logic [6:0]  GROUP_RST  = 7'd5;

    localparam logic [10:0] SIZE_MAX = 11'd1024;

    // Depth code and glyph constants
    localparam int          CODE_DIV   = 200;
    localparam int          CODE_LIMIT = 12;
    localparam int          GLYPH_TOP  = 11;
    localparam logic [9:0]  BIN_MAX    = 10'd1023;
    localparam logic [7:0]  NEWLINE    = 8'd10;

    // Shared divider width
    localparam int DIV_W = 11;

    // Output queue depth
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;

    typedef struct packed {
        logic [7:0] glyph;
        logic       last;
    } out_item_t;

    // Results pushed by the update stage in one cycle
    typedef struct packed {
        logic [1:0] cnt;
        out_item_t  first;
        out_item_t  second;
    } push_t;

    // Depth in mm to code depth/200; 0 when outside 1..11
    function automatic logic [3:0] depth_code(input logic [15:0] depth);
        logic [3:0] c;
        c = 4'd0;
        if (depth < 16'(CODE_LIMIT * CODE_DIV))
        begin
            for (int k = 1; k < CODE_LIMIT; k++)
            begin
                if (depth >= 16'(k * CODE_DIV))
                begin
                    c = 4'(k);
                end
            end
        end
        return c;
    endfunction

    // Shading ramp " M@#&$%*o!;."
    function automatic logic [7:0] shade(input logic [3:0] g);
        logic [7:0] ch;
        case (g)
            4'd0:    ch = 8'h20;
            4'd1:    ch = 8'h4D;
            4'd2:    ch = 8'h40;
            4'd3:    ch = 8'h23;
            4'd4:    ch = 8'h26;
            4'd5:    ch = 8'h24;
            4'd6:    ch = 8'h25;
            4'd7:    ch = 8'h2A;
            4'd8:    ch = 8'h6F;
            4'd9:    ch = 8'h21;
            4'd10:   ch = 8'h3B;
            default: ch = 8'h2E;
        endcase
        return ch;
    endfunction

endpackage

// File: hw/rtl/depth_bin_ascii_render.sv
// Top level of the depth bin ASCII renderer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Depth pixels (16-bit mm) come in raster order on the s_ channel; shading
// glyphs and newlines leave on the m_ channel, glyph in m_tdata and m_tlast
// marking the final result caused by one pixel. Registers are set over the
// APB port (frame_width 0x0, frame_height 0x4, column_step 0x8, row_group 0xC).
// Each accepted pixel reads its column bin from the bin memory, the next
// cycle adds its code, renders and writes back (forwarded when the following
// pixel hits the same bin), and its results enter a small queue from which
// the receiver takes them in order. Off render rows one pixel is accepted a
// cycle; on render rows the rate follows the output, one result per cycle,
// and s_tready drops unless the queue has room for two more results beyond
// those of the pixel in the update stage.
// After reset and after every register write the column phase, bin index,
// rendered-bin limit and row phase are recomputed with a shared 11-step
// divider, one division after the other; s_tready stays low meanwhile.
// The bin memory is not cleared: row 0 of each frame overwrites the bins.
// When the receiver stalls, results wait in the queue and input is held off.
module depth_bin_ascii_render
#(
    parameter int MAX_BINS = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Pixel input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] depth_mm
    // Glyph output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] glyph
    output logic        m_tlast
);

    localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

    // Recompute sequencer codes
    localparam logic [2:0] ST_COL_GO   = 3'd0;
    localparam logic [2:0] ST_COL_WAIT = 3'd1;
    localparam logic [2:0] ST_WID_GO   = 3'd2;
    localparam logic [2:0] ST_WID_WAIT = 3'd3;
    localparam logic [2:0] ST_ROW_GO   = 3'd4;
    localparam logic [2:0] ST_ROW_WAIT = 3'd5;
    localparam logic [2:0] ST_RUN      = 3'd6;

    // Configuration registers
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic [4:0]  step_reg;
    logic [6:0]  group_reg;
    logic [10:0] width_eff;
    logic [10:0] height_eff;
    logic [4:0]  step_eff;
    logic [6:0]  group_eff;
    logic        cfg_wr;

    // Position state
    logic [2:0]  state_reg,  state_next;
    logic [9:0]  col_reg,    col_next;
    logic [9:0]  row_reg,    row_next;
    logic [4:0]  cphase_reg, cphase_next;
    logic [9:0]  idx_reg,    idx_next;
    logic [6:0]  rphase_reg, rphase_next;
    logic [10:0] limit_reg,  limit_next;

    // Divider
    logic                    div_start;
    logic [dba_pkg::DIV_W-1:0] div_dividend;
    logic [6:0]              div_divisor;
    logic                    div_done;
    logic [dba_pkg::DIV_W-1:0] div_quot;
    logic [6:0]              div_rem;

    // Glyph thresholds k*row_group
    logic [10:0] thr_reg [dba_pkg::GLYPH_TOP];

    // Accept stage
    logic          accept;
    logic          a_row_end;
    logic          a_render_row;
    logic          a_sampled;
    logic [AW-1:0] a_addr;

    // Update stage
    logic          b_valid_reg;
    logic          b_sampled_reg;
    logic          b_row0_reg;
    logic          b_render_reg;
    logic          b_newline_reg;
    logic [3:0]    b_code_reg;
    logic [AW-1:0] b_addr_reg;
    logic          b_fwd_reg;
    logic [9:0]    b_fwd_data_reg;
    logic [9:0]    ram_q;
    logic [9:0]    old_bin;
    logic [10:0]   sum_bin;
    logic [9:0]    new_bin;
    logic [3:0]    g_idx;
    logic [7:0]    glyph_b;
    logic          wr_en;
    logic [9:0]    wr_data;
    logic          emit_g;
    logic          emit_nl;

    dba_pkg::push_t             push;
    dba_pkg::out_item_t         out_item;
    logic [dba_pkg::FIFO_AW:0]  fifo_count;

    // Register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= dba_pkg::WIDTH_RST;
            height_reg <= dba_pkg::HEIGHT_RST;
            step_reg   <= dba_pkg::STEP_RST;
            group_reg  <= dba_pkg::GROUP_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                dba_pkg::REG_FRAME_WIDTH:  width_reg  <= pwdata[10:0];
                dba_pkg::REG_FRAME_HEIGHT: height_reg <= pwdata[10:0];
                dba_pkg::REG_COLUMN_STEP:  step_reg   <= pwdata[4:0];
                dba_pkg::REG_ROW_GROUP:    group_reg  <= pwdata[6:0];
                default:                   width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            dba_pkg::REG_FRAME_WIDTH:  prdata = {21'd0, width_reg};
            dba_pkg::REG_FRAME_HEIGHT: prdata = {21'd0, height_reg};
            dba_pkg::REG_COLUMN_STEP:  prdata = {27'd0, step_reg};
            dba_pkg::REG_ROW_GROUP:    prdata = {25'd0, group_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // Zero acts as one; sizes above 1024 act as 1024
    always_comb
    begin
        width_eff  = (width_reg == 11'd0) ? 11'd1 :
                     (width_reg > dba_pkg::SIZE_MAX) ? dba_pkg::SIZE_MAX : width_reg;
        height_eff = (height_reg == 11'd0) ? 11'd1 :
                     (height_reg > dba_pkg::SIZE_MAX) ? dba_pkg::SIZE_MAX : height_reg;
        step_eff   = (step_reg == 5'd0) ? 5'd1 : step_reg;
        group_eff  = (group_reg == 7'd0) ? 7'd1 : group_reg;
    end

    // Glyph thresholds follow row_group; settled long before the next pixel
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < dba_pkg::GLYPH_TOP; k++)
        begin
            thr_reg[k] <= 11'(group_eff) * 11'(k + 1);
        end
    end

    // Shared divider operands
    always_comb
    begin
        div_start    = (state_reg == ST_COL_GO) || (state_reg == ST_WID_GO)
                       || (state_reg == ST_ROW_GO);
        div_dividend = {1'b0, col_reg};
        div_divisor  = {2'b0, step_eff};
        if (state_reg == ST_WID_GO)
        begin
            div_dividend = width_eff;
        end
        else if (state_reg == ST_ROW_GO)
        begin
            div_dividend = {1'b0, row_reg};
            div_divisor  = group_eff;
        end
    end

    dba_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // Accept stage decode
    assign s_tready = (state_reg == ST_RUN)
                      && ((fifo_count + (b_valid_reg ? 4'd2 : 4'd0))
                          <= 4'(dba_pkg::FIFO_DEPTH - 2));
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        a_row_end    = ({1'b0, col_reg} + 11'd1) >= width_eff;
        a_render_row = (group_eff == 7'd1) || (rphase_reg == 7'd1);
        a_sampled    = (cphase_reg == 5'd0) && (32'(idx_reg) < 32'(MAX_BINS));
        a_addr       = AW'(idx_reg);
    end

    // Sequencer and position counters
    always_comb
    begin
        state_next  = state_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        cphase_next = cphase_reg;
        idx_next    = idx_reg;
        rphase_next = rphase_reg;
        limit_next  = limit_reg;
        case (state_reg)
            ST_COL_GO:   state_next = ST_COL_WAIT;
            ST_COL_WAIT:
            begin
                if (div_done)
                begin
                    cphase_next = div_rem[4:0];
                    idx_next    = div_quot[9:0];
                    state_next  = ST_WID_GO;
                end
            end
            ST_WID_GO:   state_next = ST_WID_WAIT;
            ST_WID_WAIT:
            begin
                if (div_done)
                begin
                    limit_next = div_quot;
                    state_next = ST_ROW_GO;
                end
            end
            ST_ROW_GO:   state_next = ST_ROW_WAIT;
            ST_ROW_WAIT:
            begin
                if (div_done)
                begin
                    rphase_next = div_rem;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (accept)
                begin
                    if (a_row_end)
                    begin
                        col_next    = '0;
                        cphase_next = '0;
                        idx_next    = '0;
                        if (({1'b0, row_reg} + 11'd1) >= height_eff)
                        begin
                            row_next    = '0;
                            rphase_next = '0;
                        end
                        else
                        begin
                            row_next    = row_reg + 10'd1;
                            rphase_next = ((rphase_reg + 7'd1) == group_eff) ? 7'd0
                                          : rphase_reg + 7'd1;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 10'd1;
                        if ((cphase_reg + 5'd1) == step_eff)
                        begin
                            cphase_next = '0;
                            idx_next    = idx_reg + 10'd1;
                        end
                        else
                        begin
                            cphase_next = cphase_reg + 5'd1;
                        end
                    end
                end
            end
            default:     state_next = ST_COL_GO;
        endcase
        // A register write invalidates the derived positions
        if (cfg_wr)
        begin
            state_next = ST_COL_GO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_COL_GO;
            col_reg    <= '0;
            row_reg    <= '0;
            cphase_reg <= '0;
            idx_reg    <= '0;
            rphase_reg <= '0;
            limit_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            cphase_reg <= cphase_next;
            idx_reg    <= idx_next;
            rphase_reg <= rphase_next;
            limit_reg  <= limit_next;
        end
    end

    // Accept to update stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_sampled_reg  <= a_sampled;
            b_row0_reg     <= row_reg == 10'd0;
            b_render_reg   <= a_render_row && ({1'b0, idx_reg} < limit_reg);
            b_newline_reg  <= a_row_end && a_render_row;
            b_code_reg     <= dba_pkg::depth_code(s_tdata);
            b_addr_reg     <= a_addr;
            b_fwd_reg      <= wr_en && (b_addr_reg == a_addr);
            b_fwd_data_reg <= wr_data;
        end
    end

    dba_bin_ram
    #(
        .DEPTH (MAX_BINS),
        .AW    (AW)
    )
    u_bins
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (b_addr_reg),
        .wr_data (wr_data),
        .rd_addr (a_addr),
        .rd_data (ram_q)
    );

    // Read-modify-write of the bin, render and clear
    always_comb
    begin
        old_bin = b_fwd_reg ? b_fwd_data_reg : ram_q;
        sum_bin = {1'b0, old_bin} + 11'(b_code_reg);
        if (b_row0_reg)
        begin
            new_bin = 10'(b_code_reg);
        end
        else if (sum_bin > {1'b0, dba_pkg::BIN_MAX})
        begin
            new_bin = dba_pkg::BIN_MAX;
        end
        else
        begin
            new_bin = sum_bin[9:0];
        end
        g_idx = 4'd0;
        for (int k = 0; k < dba_pkg::GLYPH_TOP; k++)
        begin
            if ({1'b0, new_bin} >= thr_reg[k])
            begin
                g_idx = 4'(k + 1);
            end
        end
        glyph_b = dba_pkg::shade(g_idx);
        wr_en   = b_valid_reg && b_sampled_reg;
        wr_data = b_render_reg ? 10'd0 : new_bin;
        emit_g  = wr_en && b_render_reg;
        emit_nl = b_valid_reg && b_newline_reg;
    end

    // Results of the pixel in the update stage
    always_comb
    begin
        push.cnt          = 2'd0;
        push.first.glyph  = glyph_b;
        push.first.last   = 1'b1;
        push.second.glyph = dba_pkg::NEWLINE;
        push.second.last  = 1'b1;
        if (emit_g && emit_nl)
        begin
            push.cnt        = 2'd2;
            push.first.last = 1'b0;
        end
        else if (emit_g)
        begin
            push.cnt = 2'd1;
        end
        else if (emit_nl)
        begin
            push.cnt         = 2'd1;
            push.first.glyph = dba_pkg::NEWLINE;
        end
    end

    dba_out_fifo u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .tvalid (m_tvalid),
        .tready (m_tready),
        .item   (out_item),
        .count  (fifo_count)
    );

    assign m_tdata = out_item.glyph;
    assign m_tlast = out_item.last;

    `DBA_ASSERT_IMP(a_cphase_range, state_reg == ST_RUN, cphase_reg < step_eff)
    `DBA_ASSERT_IMP(a_rphase_range, state_reg == ST_RUN, rphase_reg < group_eff)
    `DBA_ASSERT_IMP(a_idx_le_col, state_reg == ST_RUN, idx_reg <= col_reg)
    `DBA_ASSERT_NEXT(a_accept_moves, accept, b_valid_reg)

endmodule

// File: hw/rtl/dba_div.sv
// Restoring divider, one quotient bit per cycle, for position recompute.
`timescale 1ns / 1ps

module dba_div
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [dba_pkg::DIV_W-1:0] dividend,
    input  logic [6:0]              divisor,
    output logic                    done,
    output logic [dba_pkg::DIV_W-1:0] quot,
    output logic [6:0]              rem
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [3:0]                    cnt_reg;
    logic [dba_pkg::DIV_W-1:0]     quo_reg;
    logic [6:0]                    rem_reg;
    logic [6:0]                    dvs_reg;
    logic [7:0]                    trial;
    logic                          ge;
    logic [6:0]                    rem_next;

    // One trial subtraction
    always_comb
    begin
        trial    = {rem_reg, quo_reg[dba_pkg::DIV_W-1]};
        ge       = trial >= {1'b0, dvs_reg};
        rem_next = ge ? 7'(trial - {1'b0, dvs_reg}) : trial[6:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 4'd1;
            if (cnt_reg == 4'(dba_pkg::DIV_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[dba_pkg::DIV_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

// File: hw/rtl/dba_bin_ram.sv
// Column bin memory: one write port, one registered read port.
`timescale 1ns / 1ps

module dba_bin_ram
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [9:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [9:0]    rd_data
);

    logic [9:0] mem [DEPTH];
    logic [9:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        q_reg <= mem[rd_addr];
    end

    assign rd_data = q_reg;

endmodule

// File: hw/rtl/dba_out_fifo.sv
// Result queue: takes up to two results a cycle, hands out one.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dba_out_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  dba_pkg::push_t      push,
    output logic                tvalid,
    input  logic                tready,
    output dba_pkg::out_item_t  item,
    output logic [dba_pkg::FIFO_AW:0] count
);

    dba_pkg::out_item_t              mem [dba_pkg::FIFO_DEPTH];
    logic [dba_pkg::FIFO_AW-1:0]     wp_reg;
    logic [dba_pkg::FIFO_AW-1:0]     rp_reg;
    logic [dba_pkg::FIFO_AW:0]       count_reg;
    logic [dba_pkg::FIFO_AW-1:0]     wp1;
    logic                            pop;

    assign wp1 = wp_reg + 1'b1;
    assign pop = tvalid && tready;

    // Entry writes
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            mem[wp_reg] <= push.first;
        end
        if (push.cnt == 2'd2)
        begin
            mem[wp1] <= push.second;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_reg + dba_pkg::FIFO_AW'(push.cnt);
            rp_reg    <= rp_reg + dba_pkg::FIFO_AW'(pop);
            count_reg <= count_reg + (dba_pkg::FIFO_AW + 1)'(push.cnt)
                         - (dba_pkg::FIFO_AW + 1)'(pop);
        end
    end

    assign tvalid = count_reg != '0;
    assign item   = mem[rp_reg];
    assign count  = count_reg;

    `DBA_ASSERT_ALWAYS(a_fifo_no_overflow, count_reg <= (dba_pkg::FIFO_AW + 1)'(dba_pkg::FIFO_DEPTH))
    `DBA_ASSERT_NEXT(a_fifo_push_shows, push.cnt != 2'd0, count_reg != '0)
    `DBA_ASSERT_IMP(a_fifo_pair_order, push.cnt == 2'd2, push.second.last && !push.first.last)

endmodule
